// ----- sv/biq_pkg.sv -----
`timescale 1ns / 1ps

package biq_pkg;

  // Field and arithmetic widths.
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 32;
  localparam int COEF_FRAC  = 28;
  localparam int STATE_W    = 32;
  localparam int STATE_FRAC = 16;

  // Digit-serial multiplier geometry.
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = COEF_W / DIGIT_W;
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);
  localparam int TERM_W     = STATE_W + DIGIT_W + 1;
  localparam int HIGH_W     = TERM_W - DIGIT_W;
  localparam int SUM_W      = STATE_W + COEF_W + 2;

  // Rounded views of the accumulator.
  localparam int RND_W_W    = SUM_W - COEF_FRAC;
  localparam int RND_Y_W    = SUM_W - COEF_FRAC - STATE_FRAC;

  // Configuration registers; the register index is also the product index.
  localparam int NUM_REGS   = 7;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);

  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  localparam reg_idx_t REG_FEED_GAIN    = reg_idx_t'(0);
  localparam reg_idx_t REG_FEEDBACK_ONE = reg_idx_t'(1);
  localparam reg_idx_t REG_FEEDBACK_TWO = reg_idx_t'(2);
  localparam reg_idx_t REG_FORWARD_ZERO = reg_idx_t'(3);
  localparam reg_idx_t REG_FORWARD_ONE  = reg_idx_t'(4);
  localparam reg_idx_t REG_FORWARD_TWO  = reg_idx_t'(5);
  localparam reg_idx_t REG_OUTPUT_GAIN  = reg_idx_t'(6);

  localparam coef_t COEF_ONE = coef_t'(1) <<< COEF_FRAC;

  localparam coef_t COEF_RESET [NUM_REGS] = '{
    COEF_ONE, coef_t'(0), coef_t'(0), COEF_ONE, coef_t'(0), coef_t'(0), COEF_ONE
  };

endpackage

// ----- sv/biquad_iir_filter.sv -----
`timescale 1ns / 1ps
// Items are taken one at a time: in_stall stays high from the accepting edge of an
// item until its result is in the output register. Seven 32x32 products share one
// digit-serial multiplier taking 4 coefficient bits per cycle (load, digits, accumulate
// each), plus round-and-saturate steps for w, ff and y and an output hand-off.
// Reset (rst_n, synchronous, active low) clears the delay line, restores the default
// coefficients (unity gains and b0, all others zero) and empties the output register.
module biquad_iir_filter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel: one sample per item.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [biq_pkg::SAMPLE_W-1:0]  in_sample,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [biq_pkg::SAMPLE_W-1:0]  out_filtered,
  output logic                                 out_clipped,
  // Configuration write port.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [biq_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic signed [biq_pkg::COEF_W-1:0]    cfg_data
);

  // The sequencer walks through the seven products in register order. Each product
  // loads its operand and coefficient, runs the coefficient through the multiplier one
  // digit per cycle, and then adds or subtracts the exact product into a wide
  // accumulator. After the feedback products the accumulator is rounded into the new
  // intermediate w, after the feedforward products into ff, and after the output gain
  // product into the output sample.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_ROUND,
    ST_OUT
  } state_t;

  state_t state_r;

  // Coefficient registers and filter state.
  biq_pkg::coef_t                        coef_r [biq_pkg::NUM_REGS];
  logic signed [biq_pkg::STATE_W-1:0]    delay_one_r;
  logic signed [biq_pkg::STATE_W-1:0]    delay_two_r;

  // Per-item working registers.
  logic signed [biq_pkg::SAMPLE_W-1:0]   sample_r;
  logic signed [biq_pkg::STATE_W-1:0]    w_r;
  logic signed [biq_pkg::STATE_W-1:0]    ff_r;
  logic signed [biq_pkg::SAMPLE_W-1:0]   y_r;
  logic                                  clip_r;
  biq_pkg::reg_idx_t                     prod_r;
  logic signed [biq_pkg::SUM_W-1:0]      sum_r;

  // Digit-serial multiplier: the coefficient shifts out of coef_sh_r one digit per
  // cycle, the partial product's upper part stays in high_r and the finished low bits
  // shift into low_r.
  logic signed [biq_pkg::STATE_W-1:0]    opnd_r;
  logic [biq_pkg::COEF_W-1:0]            coef_sh_r;
  logic signed [biq_pkg::HIGH_W-1:0]     high_r;
  logic [biq_pkg::COEF_W-1:0]            low_r;
  logic [biq_pkg::DIG_CNT_W-1:0]         dig_r;

  // Output register.
  logic                                  out_valid_r;
  logic signed [biq_pkg::SAMPLE_W-1:0]   out_filtered_r;
  logic                                  out_clipped_r;

  // Multiplier datapath. All digits but the top one are unsigned; the top one carries
  // the coefficient's sign.
  logic                                  last_digit;
  logic signed [biq_pkg::DIGIT_W:0]      digit;
  logic signed [biq_pkg::TERM_W-1:0]     term;
  logic signed [biq_pkg::TERM_W-1:0]     partial;
  logic signed [biq_pkg::SUM_W-1:0]      product;
  logic                                  subtract;

  assign last_digit = (dig_r == biq_pkg::DIG_CNT_W'(biq_pkg::NUM_DIGITS - 1));
  assign digit      = last_digit
                      ? {coef_sh_r[biq_pkg::DIGIT_W-1], coef_sh_r[biq_pkg::DIGIT_W-1:0]}
                      : {1'b0, coef_sh_r[biq_pkg::DIGIT_W-1:0]};
  assign term       = biq_pkg::TERM_W'(opnd_r) * biq_pkg::TERM_W'(digit);
  assign partial    = biq_pkg::TERM_W'(high_r) + term;
  assign product    = biq_pkg::SUM_W'($signed({high_r, low_r}));
  assign subtract   = (prod_r == biq_pkg::REG_FEEDBACK_ONE) ||
                      (prod_r == biq_pkg::REG_FEEDBACK_TWO);

  // Operand for the product about to start.
  logic signed [biq_pkg::STATE_W-1:0]    opnd_sel;

  always_comb begin
    case (prod_r)
      biq_pkg::REG_FEED_GAIN: begin
        opnd_sel = {sample_r, {biq_pkg::STATE_FRAC{1'b0}}};
      end
      biq_pkg::REG_FEEDBACK_ONE,
      biq_pkg::REG_FORWARD_ONE: begin
        opnd_sel = delay_one_r;
      end
      biq_pkg::REG_FEEDBACK_TWO,
      biq_pkg::REG_FORWARD_TWO: begin
        opnd_sel = delay_two_r;
      end
      biq_pkg::REG_FORWARD_ZERO: begin
        opnd_sel = w_r;
      end
      default: begin
        opnd_sel = ff_r;
      end
    endcase
  end

  // Round half up and saturate. The intermediate and feedforward sums drop the
  // coefficient fraction bits; the output drops the state fraction bits as well.
  logic                                  final_round;
  logic signed [biq_pkg::SUM_W-1:0]      half;
  logic signed [biq_pkg::SUM_W-1:0]      rounded;
  logic signed [biq_pkg::RND_W_W-1:0]    rnd_state;
  logic signed [biq_pkg::RND_Y_W-1:0]    rnd_out;
  logic [biq_pkg::RND_W_W-biq_pkg::STATE_W:0]  state_top;
  logic [biq_pkg::RND_Y_W-biq_pkg::SAMPLE_W:0] out_top;
  logic                                  state_fits;
  logic                                  out_fits;
  logic signed [biq_pkg::STATE_W-1:0]    state_sat;
  logic signed [biq_pkg::SAMPLE_W-1:0]   out_sat;

  assign final_round = (prod_r == biq_pkg::REG_OUTPUT_GAIN);
  assign half        = final_round
                       ? (biq_pkg::SUM_W'(1) <<< (biq_pkg::COEF_FRAC + biq_pkg::STATE_FRAC - 1))
                       : (biq_pkg::SUM_W'(1) <<< (biq_pkg::COEF_FRAC - 1));
  assign rounded     = sum_r + half;
  assign rnd_state   = rounded[biq_pkg::SUM_W-1:biq_pkg::COEF_FRAC];
  assign rnd_out     = rounded[biq_pkg::SUM_W-1:biq_pkg::COEF_FRAC+biq_pkg::STATE_FRAC];
  assign state_top   = rnd_state[biq_pkg::RND_W_W-1:biq_pkg::STATE_W-1];
  assign out_top     = rnd_out[biq_pkg::RND_Y_W-1:biq_pkg::SAMPLE_W-1];
  assign state_fits  = (&state_top) || !(|state_top);
  assign out_fits    = (&out_top) || !(|out_top);

  always_comb begin
    if (state_fits) begin
      state_sat = rnd_state[biq_pkg::STATE_W-1:0];
    end else if (rnd_state[biq_pkg::RND_W_W-1]) begin
      state_sat = {1'b1, {(biq_pkg::STATE_W-1){1'b0}}};
    end else begin
      state_sat = {1'b0, {(biq_pkg::STATE_W-1){1'b1}}};
    end
    if (out_fits) begin
      out_sat = rnd_out[biq_pkg::SAMPLE_W-1:0];
    end else if (rnd_out[biq_pkg::RND_Y_W-1]) begin
      out_sat = {1'b1, {(biq_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      out_sat = {1'b0, {(biq_pkg::SAMPLE_W-1){1'b1}}};
    end
  end

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      delay_one_r <= '0;
      delay_two_r <= '0;
      for (int i = 0; i < biq_pkg::NUM_REGS; i++) begin
        coef_r[i] <= biq_pkg::COEF_RESET[i];
      end
    end else begin
      // Writes to an index beyond the register list are dropped.
      if (cfg_valid && (int'(cfg_index) < biq_pkg::NUM_REGS)) begin
        coef_r[cfg_index] <= cfg_data;
      end

      // The hand-off state drives the output register itself.
      if (!out_stall && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            sample_r <= in_sample;
            prod_r   <= biq_pkg::REG_FEED_GAIN;
            sum_r    <= '0;
            clip_r   <= 1'b0;
            state_r  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          opnd_r    <= opnd_sel;
          coef_sh_r <= coef_r[prod_r];
          high_r    <= '0;
          low_r     <= '0;
          dig_r     <= '0;
          state_r   <= ST_MUL;
        end
        ST_MUL: begin
          high_r    <= partial[biq_pkg::TERM_W-1:biq_pkg::DIGIT_W];
          low_r     <= {partial[biq_pkg::DIGIT_W-1:0],
                        low_r[biq_pkg::COEF_W-1:biq_pkg::DIGIT_W]};
          coef_sh_r <= coef_sh_r >> biq_pkg::DIGIT_W;
          dig_r     <= dig_r + biq_pkg::DIG_CNT_W'(1);
          if (last_digit) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          sum_r <= subtract ? (sum_r - product) : (sum_r + product);
          if ((prod_r == biq_pkg::REG_FEEDBACK_TWO) ||
              (prod_r == biq_pkg::REG_FORWARD_TWO) ||
              (prod_r == biq_pkg::REG_OUTPUT_GAIN)) begin
            state_r <= ST_ROUND;
          end else begin
            prod_r  <= prod_r + biq_pkg::reg_idx_t'(1);
            state_r <= ST_LOAD;
          end
        end
        ST_ROUND: begin
          sum_r <= '0;
          if (prod_r == biq_pkg::REG_OUTPUT_GAIN) begin
            y_r     <= out_sat;
            clip_r  <= clip_r | !out_fits;
            state_r <= ST_OUT;
          end else begin
            if (prod_r == biq_pkg::REG_FEEDBACK_TWO) begin
              w_r <= state_sat;
            end else begin
              ff_r <= state_sat;
            end
            clip_r  <= clip_r | !state_fits;
            prod_r  <= prod_r + biq_pkg::reg_idx_t'(1);
            state_r <= ST_LOAD;
          end
        end
        ST_OUT: begin
          // Hand the result over once the output register is free, then shift the
          // delay line.
          if (!out_valid_r || !out_stall) begin
            out_valid_r    <= 1'b1;
            out_filtered_r <= y_r;
            out_clipped_r  <= clip_r;
            delay_two_r    <= delay_one_r;
            delay_one_r    <= w_r;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign out_clipped  = out_clipped_r;

endmodule

// ----- verif/tb_biquad_iir_filter.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the biquad section.
//
// Samples are queued by the sequence block below and presented by a clocked
// driver. The driver runs every accepted item through a bit-exact model of the
// direct form II section, so the expected output is known as soon as the
// block takes the sample. A clocked monitor drains the result channel and
// compares both fields against the oldest expectation.
//
// Coefficients are only rewritten once the block has gone quiet: every queued
// sample has been taken and every expected output has come back. Since each
// sample yields exactly one output, an empty expectation queue means the
// datapath is idle.
module tb_biquad_iir_filter;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 11;
  // Watchdog limit for the whole run, in nanoseconds.
  localparam int TIMEOUT_NS    = 14_400_000;
  // Latency of the block plus some margin, waited out before the verdict.
  localparam int TAIL_CYCLES   = 100;

  localparam int SEND_IDLE_PCT = 38;
  localparam int RECV_IDLE_PCT = 48;

  // One long receiver hold-off, started once this many samples have been
  // accepted. It covers several sample periods, so the block fills up and
  // has to stall its input.
  localparam int HOLD_AT       = 60;
  localparam int HOLD_CYCLES   = 600;

  localparam int NUM_SETTINGS  = 8;
  localparam int BATCH_SIZE    = 100;

  typedef logic signed [biq_pkg::SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic signed [biq_pkg::SAMPLE_W-1:0] filtered;
    logic                                clipped;
  } filter_out_t;

  // Q4.28 reference points.
  localparam int             COEF_UNITY = 268435456;
  localparam biq_pkg::coef_t COEF_MAX   = 32'sh7fff_ffff;
  localparam biq_pkg::coef_t COEF_MIN   = 32'sh8000_0000;
  localparam biq_pkg::coef_t COEF_HALF  = biq_pkg::coef_t'(COEF_UNITY / 2);
  localparam biq_pkg::coef_t COEF_NEG   = biq_pkg::coef_t'(-COEF_UNITY);
  // Largest |a2| used for the stable filters: 0.85 in Q4.28.
  localparam int             FB2_SPAN   = 228170137;

  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  // The index field can address one slot above the last register. Writes to
  // that slot must be dropped by the block.
  localparam biq_pkg::reg_idx_t REG_UNMAPPED = biq_pkg::reg_idx_t'(biq_pkg::NUM_REGS);

  // Power-up values: unity input gain, b0 and output gain. Everything else
  // is zero, which makes the section a straight pass-through.
  localparam biq_pkg::coef_t RESET_COEFS [biq_pkg::NUM_REGS] = '{
    biq_pkg::coef_t'(COEF_UNITY), biq_pkg::coef_t'(0), biq_pkg::coef_t'(0),
    biq_pkg::coef_t'(COEF_UNITY), biq_pkg::coef_t'(0), biq_pkg::coef_t'(0),
    biq_pkg::coef_t'(COEF_UNITY)
  };

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  sample_t           in_sample = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  sample_t           out_filtered;
  logic              out_clipped;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  biq_pkg::reg_idx_t cfg_index = '0;
  biq_pkg::coef_t    cfg_data  = '0;

  biquad_iir_filter uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filtered (out_filtered),
    .out_clipped  (out_clipped),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the block's coefficients and delay line.
  biq_pkg::coef_t                      coef_shadow [biq_pkg::NUM_REGS];
  logic signed [biq_pkg::STATE_W-1:0]  delay_one;
  logic signed [biq_pkg::STATE_W-1:0]  delay_two;

  sample_t     sample_q[$];
  filter_out_t filtered_q[$];

  int send_idle_pct = SEND_IDLE_PCT;
  int recv_idle_pct = RECV_IDLE_PCT;
  int samples_sent  = 0;
  int results_seen  = 0;
  int clipped_seen  = 0;
  int input_stalls  = 0;
  int cfg_writes    = 0;
  int coef_sets     = 0;
  int mismatches    = 0;
  int hold_left;
  bit hold_done;

  // Round half up by frac_bits (add half, then floor) and clamp the result to
  // a keep_bits wide signed range. The sat flag reports whether clamping
  // happened.
  function automatic logic signed [63:0] round_sat(input logic signed [95:0] v,
                                                   input int frac_bits,
                                                   input int keep_bits,
                                                   output bit sat);
    logic signed [95:0] r;
    logic signed [95:0] top;
    logic signed [95:0] bottom;
    r      = (v + (96'sd1 <<< (frac_bits - 1))) >>> frac_bits;
    top    = (96'sd1 <<< (keep_bits - 1)) - 96'sd1;
    bottom = -(96'sd1 <<< (keep_bits - 1));
    sat    = (r > top) || (r < bottom);
    if (r > top) begin
      r = top;
    end else if (r < bottom) begin
      r = bottom;
    end
    return r[63:0];
  endfunction

  // Filters one sample and advances the shadow delay line.
  // All products are exact in 96 bits, and rounding happens only at the
  // three points where the hardware narrows:
  //   w  = g0*x - a1*d1 - a2*d2              -> Q16.16, state width
  //   ff = b0*w + b1*d1 + b2*d2              -> Q16.16, state width
  //   y  = g1*ff                             -> sample width
  function automatic filter_out_t filter_step(input sample_t x);
    logic signed [47:0] x_q16;
    logic signed [95:0] acc;
    logic signed [63:0] w;
    logic signed [63:0] ff;
    logic signed [63:0] y;
    bit                 sat_w;
    bit                 sat_ff;
    bit                 sat_y;
    filter_out_t        r;
    x_q16 = x;
    x_q16 = x_q16 <<< biq_pkg::STATE_FRAC;
    acc = coef_shadow[biq_pkg::REG_FEED_GAIN] * x_q16
        - coef_shadow[biq_pkg::REG_FEEDBACK_ONE] * delay_one
        - coef_shadow[biq_pkg::REG_FEEDBACK_TWO] * delay_two;
    w = round_sat(acc, biq_pkg::COEF_FRAC, biq_pkg::STATE_W, sat_w);
    acc = coef_shadow[biq_pkg::REG_FORWARD_ZERO] * w
        + coef_shadow[biq_pkg::REG_FORWARD_ONE] * delay_one
        + coef_shadow[biq_pkg::REG_FORWARD_TWO] * delay_two;
    ff = round_sat(acc, biq_pkg::COEF_FRAC, biq_pkg::STATE_W, sat_ff);
    acc = coef_shadow[biq_pkg::REG_OUTPUT_GAIN] * ff;
    y = round_sat(acc, biq_pkg::COEF_FRAC + biq_pkg::STATE_FRAC, biq_pkg::SAMPLE_W, sat_y);
    // The delay line stores the saturated w.
    delay_two  = delay_one;
    delay_one  = w[biq_pkg::STATE_W-1:0];
    r.filtered = y[biq_pkg::SAMPLE_W-1:0];
    r.clipped  = sat_w | sat_ff | sat_y;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Input driver. A new sample is put up only once the previous one has been
  // taken, so a stalled sample never changes. Idle gaps are rolled per slot.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_sample <= '0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        filtered_q.push_back(filter_step(in_sample));
        samples_sent++;
      end
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid  <= 1'b1;
        in_sample <= sample_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else begin
      input_stalls++;
    end
  end

  // Long receiver hold-off. It runs once, and the driver keeps offering
  // samples the whole time.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && samples_sent >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Result monitor. It checks every item taken on the result channel and then
  // decides whether to stall the next cycle.
  always @(posedge clk) begin
    filter_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          note_mismatch($sformatf("unexpected output %0d (clipped %0b)",
                                  out_filtered, out_clipped));
        end else begin
          want = filtered_q.pop_front();
          if (out_filtered !== want.filtered) begin
            note_mismatch($sformatf("output %0d filtered: expected %0d, got %0d",
                                    results_seen, want.filtered, out_filtered));
          end
          if (out_clipped !== want.clipped) begin
            note_mismatch($sformatf("output %0d clipped: expected %0b, got %0b",
                                    results_seen, want.clipped, out_clipped));
          end
        end
        results_seen++;
        if (out_clipped === 1'b1) begin
          clipped_seen++;
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Configuration writes are issued only from the sequence block, and only
  // while the block is idle.
  task automatic write_coef(input biq_pkg::reg_idx_t idx, input biq_pkg::coef_t value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < biq_pkg::NUM_REGS) begin
      coef_shadow[idx] = value;
    end
    cfg_writes++;
  endtask

  task automatic write_all(input biq_pkg::coef_t vals [biq_pkg::NUM_REGS]);
    foreach (vals[i]) begin
      write_coef(biq_pkg::reg_idx_t'(i), vals[i]);
    end
    coef_sets++;
  endtask

  // Checks are made on the falling edge, after every clocked update of the
  // rising edge has settled.
  task automatic wait_drained();
    do @(negedge clk); while (sample_q.size() != 0 || in_valid || filtered_q.size() != 0);
  endtask

  function automatic biq_pkg::coef_t within_unity();
    return biq_pkg::coef_t'(int'($urandom_range(0, 2 * COEF_UNITY)) - COEF_UNITY);
  endfunction

  // A stable filter keeps the state mostly in range, so rounding is what gets
  // exercised. A wild filter uses raw 32-bit coefficients and saturates
  // constantly.
  task automatic load_filter(input bit wild);
    biq_pkg::coef_t vals [biq_pkg::NUM_REGS];
    int             fb2;
    int             lim;
    if (wild) begin
      foreach (vals[i]) begin
        vals[i] = biq_pkg::coef_t'($urandom());
      end
    end else begin
      // Stay inside the stability triangle: |a2| < 1 and |a1| < 1 + a2.
      fb2 = int'($urandom_range(0, 2 * FB2_SPAN)) - FB2_SPAN;
      lim = (COEF_UNITY + fb2) / 10 * 9;
      vals[biq_pkg::REG_FEED_GAIN]    = within_unity();
      vals[biq_pkg::REG_FEEDBACK_ONE] = biq_pkg::coef_t'(int'($urandom_range(0, 2 * lim)) - lim);
      vals[biq_pkg::REG_FEEDBACK_TWO] = biq_pkg::coef_t'(fb2);
      vals[biq_pkg::REG_FORWARD_ZERO] = within_unity();
      vals[biq_pkg::REG_FORWARD_ONE]  = within_unity();
      vals[biq_pkg::REG_FORWARD_TWO]  = within_unity();
      vals[biq_pkg::REG_OUTPUT_GAIN]  = within_unity();
    end
    write_all(vals);
    if (wild) begin
      write_coef(REG_UNMAPPED, biq_pkg::coef_t'($urandom()));
    end
  endtask

  // Mix of full-scale noise, small signals that stress rounding, rail values
  // and held values that give step responses.
  function automatic sample_t random_sample(input sample_t prev);
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      1, 2, 3: return sample_t'(int'($urandom_range(0, 512)) - 256);
      4, 5:    return prev;
      default: return sample_t'($urandom());
    endcase
  endfunction

  initial begin
    sample_t        pass_thru [8];
    sample_t        rails [6];
    sample_t        halves [6];
    sample_t        negate [3];
    biq_pkg::coef_t vals [biq_pkg::NUM_REGS];
    sample_t        prev;

    pass_thru = '{16'sd0, 16'sd1, -16'sd1, SAMPLE_MAX, SAMPLE_MIN,
                  16'sh5555, 16'shaaaa, 16'sd12345};
    rails     = '{SAMPLE_MAX, SAMPLE_MIN, 16'sd0, 16'sd1, -16'sd1, 16'sd100};
    halves    = '{16'sd1, -16'sd1, 16'sd3, -16'sd3, SAMPLE_MAX, SAMPLE_MIN};
    negate    = '{SAMPLE_MIN, SAMPLE_MAX, 16'sd0};

    foreach (coef_shadow[i]) begin
      coef_shadow[i] = RESET_COEFS[i];
    end
    delay_one = '0;
    delay_two = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // The power-up coefficients must pass samples through unchanged, rails
    // included.
    foreach (pass_thru[i]) sample_q.push_back(pass_thru[i]);
    wait_drained();

    // Every register is set to a rail, with alternating signs, so each of
    // the three saturation points trips. A write to the unused index in
    // between must change nothing.
    vals = '{COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX};
    write_all(vals);
    write_coef(REG_UNMAPPED, biq_pkg::coef_t'(0));
    foreach (rails[i]) sample_q.push_back(rails[i]);
    wait_drained();

    // A half output gain puts every odd sample on a rounding tie. Ties must
    // round up, so -1 becomes 0 while 1 becomes 1.
    vals = '{biq_pkg::coef_t'(COEF_UNITY), biq_pkg::coef_t'(0), biq_pkg::coef_t'(0),
             biq_pkg::coef_t'(COEF_UNITY), biq_pkg::coef_t'(0), biq_pkg::coef_t'(0),
             COEF_HALF};
    write_all(vals);
    foreach (halves[i]) sample_q.push_back(halves[i]);
    wait_drained();

    // Negating the most negative sample overflows only the output stage.
    write_coef(biq_pkg::REG_OUTPUT_GAIN, COEF_NEG);
    foreach (negate[i]) sample_q.push_back(negate[i]);
    wait_drained();

    // Random filters. Idling moves from a slower receiver to a slower sender and
    // ends with both sides running flat out.
    prev = '0;
    for (int set_no = 0; set_no < NUM_SETTINGS; set_no++) begin
      if (set_no == 3) begin
        send_idle_pct <= RECV_IDLE_PCT;
        recv_idle_pct <= SEND_IDLE_PCT;
      end else if (set_no == 6) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      load_filter(set_no % 3 == 2);
      for (int i = 0; i < BATCH_SIZE; i++) begin
        prev = random_sample(prev);
        sample_q.push_back(prev);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Filtered %0d samples (%0d saturated) under %0d coefficient sets.",
             results_seen, clipped_seen, coef_sets);
    $display("%0d register writes; input held off for %0d cycles; %0d mismatches found.",
             cfg_writes, input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("biquad_iir_filter test passed");
    end else begin
      $display("biquad_iir_filter test failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out: %0d samples queued, %0d outputs outstanding.",
             sample_q.size(), filtered_q.size());
    $display("biquad_iir_filter test failed");
    $finish;
  end

endmodule

// ----- biquad_iir_filter.f -----
sv/biq_pkg.sv
sv/biquad_iir_filter.sv
verif/tb_biquad_iir_filter.sv
